>>> rtl/hqw_pkg.sv
// Shared types for the Huber quality-control weight block.
// No dependencies.
package hqw_pkg;

  // How the final stage picks the weight.
  typedef enum logic [1:0] {
    WSEL_ONE  = 2'd0,
    WSEL_ZERO = 2'd1,
    WSEL_CALC = 2'd2
  } wsel_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic  valid;
    wsel_t wsel;
    logic  outlier;
    logic  bad;
  } ctl_t;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_CLEFT  = 2'd1;
  localparam logic [1:0] CFG_CRIGHT = 2'd2;

endpackage

>>> rtl/hqw_if.sv
// Valid/ready channel interfaces for input and result words.
// No dependencies.
interface hqw_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] departure;
  logic [DATA_WIDTH-2:0]        obs_stddev;
  modport source (output valid, departure, obs_stddev, input ready);
  modport sink (input valid, departure, obs_stddev, output ready);
endinterface

interface hqw_out_if #(parameter int DATA_WIDTH = 32, parameter int FRAC_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [FRAC_BITS:0]           weight_sqrt;
  logic signed [DATA_WIDTH-1:0] weighted_departure;
  logic                         is_outlier;
  logic                         bad_stddev;
  modport source (output valid, weight_sqrt, weighted_departure, is_outlier, bad_stddev,
                  input ready);
  modport sink (input valid, weight_sqrt, weighted_departure, is_outlier, bad_stddev,
                output ready);
endinterface

>>> rtl/hqw_prep.sv
// Front of the pipeline: classify the departure, then form a^2 and c*(2a-c).
// Depends on hqw_pkg.
module hqw_prep import hqw_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [DATA_WIDTH-1:0]        departure,
  input  logic [DATA_WIDTH-2:0]               obs_stddev,
  input  logic                                varqc_enable,
  input  logic signed [DATA_WIDTH-1:0]        c_left,
  input  logic [DATA_WIDTH-2:0]               c_right,
  output ctl_t                                ctl_o,
  output logic signed [DATA_WIDTH-1:0]        d_o,
  output logic [2*DATA_WIDTH-1:0]             a2_o,
  output logic [2*DATA_WIDTH+2*FRAC_BITS-1:0] e_o
);
  localparam int D = DATA_WIDTH;
  localparam int W = 2*DATA_WIDTH + 2*FRAC_BITS;

  logic signed [D-1:0] cl_sat;
  logic                below, above, outl;
  logic [D-1:0]        a_nxt, c_nxt;
  ctl_t                ctl1_nxt;

  ctl_t                ctl1_r, ctl2_r;
  logic signed [D-1:0] d1_r, d2_r;
  logic [D-1:0]        a1_r, c1_r;
  logic [2*D-1:0]      a2_r;
  logic [2*D:0]        r_r;
  logic [D:0]          twoa_c;

  always_comb begin
    cl_sat = (c_left > 0) ? '0 : c_left;
    below  = varqc_enable && (departure < cl_sat);
    above  = varqc_enable && ($signed({departure[D-1], departure}) >
                              $signed({2'b00, c_right}));
    outl   = below || above;
    a_nxt  = below ? D'(-departure) : D'(departure);
    c_nxt  = below ? D'(-cl_sat) : {1'b0, c_right};
    ctl1_nxt.valid   = in_valid;
    ctl1_nxt.outlier = outl;
    ctl1_nxt.bad     = outl && (obs_stddev == '0);
    if (!outl) begin
      ctl1_nxt.wsel = WSEL_ONE;
    end else if (obs_stddev == '0) begin
      ctl1_nxt.wsel = WSEL_ZERO;
    end else begin
      ctl1_nxt.wsel = WSEL_CALC;
    end
    twoa_c = {a1_r, 1'b0} - {1'b0, c1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
    end else if (en) begin
      ctl1_r.valid <= ctl1_nxt.valid;
      ctl2_r.valid <= ctl1_r.valid;
    end
    if (en) begin
      ctl1_r.wsel    <= ctl1_nxt.wsel;
      ctl1_r.outlier <= ctl1_nxt.outlier;
      ctl1_r.bad     <= ctl1_nxt.bad;
      d1_r <= departure;
      a1_r <= a_nxt;
      c1_r <= c_nxt;
      ctl2_r.wsel    <= ctl1_r.wsel;
      ctl2_r.outlier <= ctl1_r.outlier;
      ctl2_r.bad     <= ctl1_r.bad;
      d2_r <= d1_r;
      a2_r <= (2*D)'(a1_r) * (2*D)'(a1_r);
      r_r  <= (2*D+1)'(c1_r) * (2*D+1)'(twoa_c);
    end
  end

  assign ctl_o = ctl2_r;
  assign d_o   = d2_r;
  assign a2_o  = a2_r;
  assign e_o   = W'(r_r) << (2*FRAC_BITS);
endmodule

>>> rtl/hqw_cell.sv
// One cell of the root search chain: decides one bit of the weight root.
// Depends on hqw_pkg.
module hqw_cell import hqw_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int BIT        = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  ctl_t                                ctl_i,
  input  logic signed [DATA_WIDTH-1:0]        d_i,
  input  logic [2*DATA_WIDTH-1:0]             a2_i,
  input  logic [2*DATA_WIDTH+2*FRAC_BITS-1:0] e_i,
  input  logic [2*DATA_WIDTH+2*FRAC_BITS-1:0] q_i,
  input  logic [FRAC_BITS:0]                  k_i,
  output ctl_t                                ctl_o,
  output logic signed [DATA_WIDTH-1:0]        d_o,
  output logic [2*DATA_WIDTH-1:0]             a2_o,
  output logic [2*DATA_WIDTH+2*FRAC_BITS-1:0] e_o,
  output logic [2*DATA_WIDTH+2*FRAC_BITS-1:0] q_o,
  output logic [FRAC_BITS:0]                  k_o
);
  localparam int W  = 2*DATA_WIDTH + 2*FRAC_BITS;
  localparam int WX = W + 3;

  // residual e = R - (k*a)^2, q = k*a^2; adding 2^b grows (ka)^2 by (2q + a^2*2^b)*2^b
  logic [WX-1:0] step, trial;
  logic          skip, take;
  ctl_t          ctl_r;
  logic signed [DATA_WIDTH-1:0] d_r;
  logic [2*DATA_WIDTH-1:0] a2_r;
  logic [W-1:0]  e_r, q_r;
  logic [FRAC_BITS:0] k_r;

  always_comb begin
    step  = WX'(a2_i) << BIT;
    trial = ((WX'(q_i) << 1) + step) << BIT;
    skip  = (BIT != FRAC_BITS) && k_i[FRAC_BITS];
    take  = !skip && (trial <= WX'(e_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
    if (en) begin
      ctl_r.wsel    <= ctl_i.wsel;
      ctl_r.outlier <= ctl_i.outlier;
      ctl_r.bad     <= ctl_i.bad;
      d_r  <= d_i;
      a2_r <= a2_i;
      e_r  <= take ? W'(WX'(e_i) - trial) : e_i;
      q_r  <= take ? W'(WX'(q_i) + step) : q_i;
      k_r  <= take ? (k_i | ((FRAC_BITS+1)'(1) << BIT)) : k_i;
    end
  end

  assign ctl_o = ctl_r;
  assign d_o   = d_r;
  assign a2_o  = a2_r;
  assign e_o   = e_r;
  assign q_o   = q_r;
  assign k_o   = k_r;
endmodule

>>> rtl/hqw_final.sv
// Last stage: pick the weight, scale the departure, hold the result word.
// Depends on hqw_pkg.
module hqw_final import hqw_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  ctl_t                         ctl_i,
  input  logic signed [DATA_WIDTH-1:0] d_i,
  input  logic [FRAC_BITS:0]           k_i,
  output logic                         valid_o,
  output logic [FRAC_BITS:0]           weight_o,
  output logic signed [DATA_WIDTH-1:0] wdep_o,
  output logic                         outlier_o,
  output logic                         bad_o
);
  localparam int D = DATA_WIDTH;
  localparam int F = FRAC_BITS;

  logic [F:0]     w;
  logic [D-1:0]   mag;
  logic [D+F:0]   prod;
  logic           valid_r, outlier_r, bad_r;
  logic [F:0]     weight_r;
  logic [D-1:0]   wdep_r;

  always_comb begin
    unique case (ctl_i.wsel)
      WSEL_ONE:  w = (F+1)'(1) << F;
      WSEL_ZERO: w = '0;
      WSEL_CALC: w = k_i;
      default:   w = '0;
    endcase
    mag  = d_i[D-1] ? D'(-d_i) : D'(d_i);
    prod = (D+F+1)'(mag[D-1:F]) * (D+F+1)'(w) +
           (((D+F+1)'(mag[F-1:0]) * (D+F+1)'(w)) >> F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_r  <= w;
      wdep_r    <= d_i[D-1] ? D'(-prod) : D'(prod);
      outlier_r <= ctl_i.outlier;
      bad_r     <= ctl_i.bad;
    end
  end

  assign valid_o   = valid_r;
  assign weight_o  = weight_r;
  assign wdep_o    = wdep_r;
  assign outlier_o = outlier_r;
  assign bad_o     = bad_r;
endmodule

>>> rtl/huber_qc_weight_unit.sv
// Top level of the Huber quality-control weight block.
// Depends on hqw_pkg, hqw_if, hqw_prep, hqw_cell, hqw_final.
//
// Usage:
//   in_ch  : one word per observation (departure, obs_stddev), valid/ready.
//   out_ch : one word per input word (weight_sqrt, weighted_departure,
//            is_outlier, bad_stddev), in input order.
//   cfg_*  : write-only registers: 0 enable, 1 c_left, 2 c_right.
//            Write only while the pipeline is empty.
// Pipeline: FRAC_BITS + 4 register stages (classify, multiply, FRAC_BITS+1
//   root cells, scale/output).
// Throughput: one word per cycle while not stalled; the root chain decides
//   one weight bit per cell, so the cell count sets the latency, not the rate.
// Stall: the whole pipeline freezes when the output word is held and not
//   taken; in_ch.ready is low only then. Bubbles keep flowing otherwise.
// Reset: synchronous, active low; clears the valid chain and sets all
//   config registers to zero (quality control off).
module huber_qc_weight_unit import hqw_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hqw_in_if.sink                in_ch,
  hqw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_wdata
);
  localparam int D = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int W = 2*D + 2*F;
  localparam int N = F + 1;   // root cells

  logic                en;
  logic                enable_r;
  logic signed [D-1:0] cleft_r;
  logic [D-2:0]        cright_r;

  // chain taps between cells
  ctl_t                ctl_s [N+1];
  logic signed [D-1:0] d_s   [N+1];
  logic [2*D-1:0]      a2_s  [N+1];
  logic [W-1:0]        e_s   [N+1];
  logic [W-1:0]        q_s   [N+1];
  logic [F:0]          k_s   [N+1];

  // advance unless a held result word is blocked
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      cleft_r  <= '0;
      cright_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_CLEFT:  cleft_r  <= cfg_wdata;
        CFG_CRIGHT: cright_r <= cfg_wdata[D-2:0];
        default:    ;
      endcase
    end
  end

  hqw_prep #(.DATA_WIDTH(D), .FRAC_BITS(F)) u_prep (
    .clk, .rst_n, .en,
    .in_valid     (in_ch.valid && in_ch.ready),
    .departure    (in_ch.departure),
    .obs_stddev   (in_ch.obs_stddev),
    .varqc_enable (enable_r),
    .c_left       (cleft_r),
    .c_right      (cright_r),
    .ctl_o        (ctl_s[0]),
    .d_o          (d_s[0]),
    .a2_o         (a2_s[0]),
    .e_o          (e_s[0])
  );

  assign q_s[0] = '0;
  assign k_s[0] = '0;

  // cell i decides weight bit F-i, MSB first
  for (genvar i = 0; i < N; i++) begin : g_cell
    hqw_cell #(.DATA_WIDTH(D), .FRAC_BITS(F), .BIT(F - i)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i (ctl_s[i]),   .d_i (d_s[i]),   .a2_i (a2_s[i]),
      .e_i   (e_s[i]),     .q_i (q_s[i]),   .k_i  (k_s[i]),
      .ctl_o (ctl_s[i+1]), .d_o (d_s[i+1]), .a2_o (a2_s[i+1]),
      .e_o   (e_s[i+1]),   .q_o (q_s[i+1]), .k_o  (k_s[i+1])
    );
  end

  hqw_final #(.DATA_WIDTH(D), .FRAC_BITS(F)) u_final (
    .clk, .rst_n, .en,
    .ctl_i     (ctl_s[N]),
    .d_i       (d_s[N]),
    .k_i       (k_s[N]),
    .valid_o   (out_ch.valid),
    .weight_o  (out_ch.weight_sqrt),
    .wdep_o    (out_ch.weighted_departure),
    .outlier_o (out_ch.is_outlier),
    .bad_o     (out_ch.bad_stddev)
  );
endmodule

>>> rtl/hqw_checker.sv
// Port-level checks on the result channel of the weight block.
// Depends on huber_qc_weight_unit (bind target).
module hqw_checker #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  in_ready,
  input logic [FRAC_BITS:0]    weight_sqrt,
  input logic [DATA_WIDTH-1:0] weighted_departure,
  input logic                  is_outlier,
  input logic                  bad_stddev
);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(weight_sqrt))
    else $error("result word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> weight_sqrt <= ONE)
    else $error("weight above one");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_stddev |-> is_outlier && weight_sqrt == '0 &&
                                weighted_departure == '0)
    else $error("zero stddev outlier not zeroed");

  a_inlier: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_outlier |-> weight_sqrt == ONE)
    else $error("inlier weight not one");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");
endmodule

bind huber_qc_weight_unit hqw_checker #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS))
  u_hqw_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .in_ready           (in_ch.ready),
    .weight_sqrt        (out_ch.weight_sqrt),
    .weighted_departure (out_ch.weighted_departure),
    .is_outlier         (out_ch.is_outlier),
    .bad_stddev         (out_ch.bad_stddev)
  );

>>> dv/hqw_sb_pkg.sv
// Scoreboard for the Huber quality-control weight block: register shadow,
// weight predictor and the queue of expected result words. Depends on nothing.
package hqw_sb_pkg;

  typedef struct {
    logic [16:0]        weight_sqrt;
    logic signed [31:0] weighted_departure;
    logic               is_outlier;
    logic               bad_stddev;
  } qc_result_t;

  class hqw_scoreboard;
    logic               enable;
    logic signed [31:0] c_left;
    logic [30:0]        c_right;
    qc_result_t         pending[$];
    int                 mismatches;

    function new();
      enable = 0;
      c_left = 0;
      c_right = 0;
      mismatches = 0;
    endfunction

    // largest k in [0, 2^16] with (k*a)^2 <= c*(2a-c)*2^32
    function logic [16:0] root_weight(logic [63:0] a, logic [63:0] c);
      logic [127:0] bound;
      logic [127:0] prod;
      logic [16:0]  k;
      logic [17:0]  cand;
      k = 0;
      bound = (128'(c) * 128'(2 * a - c)) << 32;
      for (int b = 16; b >= 0; b--) begin
        cand = 18'(k) | (18'd1 << b);
        if (cand <= 18'h10000) begin
          prod = 128'(cand) * 128'(a);
          if (prod * prod <= bound) k = cand[16:0];
        end
      end
      return k;
    endfunction

    function void note_word(logic signed [31:0] d, logic [30:0] sd);
      qc_result_t  r;
      logic signed [63:0] dl, lo;
      logic [63:0] a, c, mag, q;
      logic [16:0] w;
      dl = d;
      lo = c_left;
      if (lo > 0) lo = 0;
      w = 17'h10000;
      r.is_outlier = 0;
      r.bad_stddev = 0;
      a = 0;
      c = 0;
      if (enable) begin
        if (dl < lo) begin
          r.is_outlier = 1;
          a = -dl;
          c = -lo;
        end else if (dl > $signed({33'd0, c_right})) begin
          r.is_outlier = 1;
          a = dl;
          c = {33'd0, c_right};
        end
        if (r.is_outlier) begin
          if (sd == 0) begin
            r.bad_stddev = 1;
            w = 0;
          end else begin
            w = root_weight(a, c);
          end
        end
      end
      mag = (dl < 0) ? -dl : dl;
      q = (mag >> 16) * w + (((mag & 64'hffff) * w) >> 16);
      r.weight_sqrt = w;
      r.weighted_departure = (dl < 0) ? 32'(-q) : 32'(q);
      pending.push_back(r);
    endfunction

    function void check_word(qc_result_t got);
      qc_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.weight_sqrt !== e.weight_sqrt ||
          got.weighted_departure !== e.weighted_departure ||
          got.is_outlier !== e.is_outlier || got.bad_stddev !== e.bad_stddev) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp w=%h wd=%h o=%b b=%b got w=%h wd=%h o=%b b=%b",
                   e.weight_sqrt, e.weighted_departure, e.is_outlier, e.bad_stddev,
                   got.weight_sqrt, got.weighted_departure, got.is_outlier,
                   got.bad_stddev);
      end
    endfunction
  endclass

endpackage

>>> dv/huber_qc_weight_unit_tb.sv
// Testbench top for huber_qc_weight_unit: drives observation words and register writes,
// checks every result word. Depends on hqw_pkg, hqw_if, hqw_sb_pkg, huber_qc_weight_unit.
module huber_qc_weight_unit_tb;
  import hqw_pkg::*;
  import hqw_sb_pkg::*;

  localparam int PIPE_LAT = 20;  // register stages, FRAC_BITS + 4

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  hqw_in_if  #(.DATA_WIDTH(32)) in_ch ();
  hqw_out_if #(.DATA_WIDTH(32), .FRAC_BITS(16)) out_ch ();

  huber_qc_weight_unit #(.DATA_WIDTH(32), .FRAC_BITS(16)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  hqw_scoreboard sb = new();
  bit no_idle;       // phase with back-to-back traffic on both sides
  int hold_request;  // cycles the receiver must hold off, 0 = none
  bit run_done;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Hard limit: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  // Registers change only with the pipeline drained.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_ENABLE: sb.enable = data[0];
      CFG_CLEFT:  sb.c_left = data;
      CFG_CRIGHT: sb.c_right = data[30:0];
      default: ;  // index beyond the list is ignored
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic set_thresholds(logic en, logic [31:0] lo, logic [31:0] hi);
    drain();
    write_reg(CFG_ENABLE, {31'd0, en});
    write_reg(CFG_CLEFT, lo);
    write_reg(CFG_CRIGHT, hi);
  endtask

  // One word on the input channel; valid is held until the handshake.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic signed [31:0] d, logic [30:0] sd);
    int gap;
    gap = draw_gap();
    repeat (gap) @(negedge clk);
    in_ch.valid = 1;
    in_ch.departure = d;
    in_ch.obs_stddev = sd;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    sb.note_word(d, sd);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  // Random departure: full range, near a threshold, or small.
  function automatic logic signed [31:0] rand_departure();
    logic signed [31:0] base;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        base = $signed({1'b0, sb.c_right});
        return base + $signed(32'($urandom_range(0, 64))) - 32;
      end
      2: return sb.c_left + $signed(32'($urandom_range(0, 64))) - 32;
      default: return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_stddev();
    return ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom);
  endfunction

  // Receiver: random back-pressure per word, plus long holds on request.
  initial begin
    qc_result_t got;
    int gap;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        out_ch.ready = 0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      gap = draw_gap();
      if (gap != 0) begin
        out_ch.ready = 0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ch.ready = 1;
      forever begin
        @(posedge clk);
        if (out_ch.valid) break;
      end
      got.weight_sqrt = out_ch.weight_sqrt;
      got.weighted_departure = out_ch.weighted_departure;
      got.is_outlier = out_ch.is_outlier;
      got.bad_stddev = out_ch.bad_stddev;
      sb.check_word(got);
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.departure = 0;
    in_ch.obs_stddev = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    no_idle = 0;
    hold_request = 0;
    run_done = 0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Reset state: quality control off, every word gets weight one.
    send_word(32'sh7fff_ffff, 31'd0);
    send_word(-32'sh8000_0000, 31'h7fff_ffff);
    send_word(32'sd0, 31'd5);
    send_word(-32'sd1, 31'd0);

    // Zero thresholds: any nonzero departure crosses a zero threshold.
    set_thresholds(1, 32'd0, 32'd0);
    write_reg(2'd3, 32'hffff_ffff);  // out-of-range index, no effect
    send_word(32'sd0, 31'd1);
    send_word(32'sd1, 31'd1);
    send_word(-32'sd1, 31'd1);
    send_word(32'sh7fff_ffff, 31'd0);

    // Ordinary thresholds: on the edges, just outside, far outside, zero stddev.
    set_thresholds(1, -32'sd131072, 32'd196608);
    send_word(32'sd196608, 31'd65536);
    send_word(32'sd196609, 31'd65536);
    send_word(-32'sd131072, 31'd65536);
    send_word(-32'sd131073, 31'd65536);
    send_word(32'sh7fff_ffff, 31'd1);
    send_word(-32'sh8000_0000, 31'd1);
    send_word(32'sd1000000, 31'd0);
    send_word(-32'sd1000000, 31'd0);

    // Extreme thresholds, then a positive c_left that saturates to zero.
    set_thresholds(1, 32'h8000_0000, 32'h7fff_ffff);
    send_word(32'sh7fff_ffff, 31'd0);
    send_word(-32'sh8000_0000, 31'd0);
    set_thresholds(1, 32'h0001_0000, 32'h7fff_fffe);
    send_word(-32'sd1, 31'd9);
    send_word(32'sh7fff_ffff, 31'd9);
    send_word(32'sd5, 31'd9);

    // Random phases; the register settings change between phases.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_thresholds(1, -32'($urandom_range(0, 32'h0010_0000)),
                          32'($urandom_range(0, 32'h0010_0000)));
        1: set_thresholds(0, $urandom, 32'($urandom));
        2: set_thresholds(1, 32'h8000_0000 | 32'($urandom_range(0, 255)),
                          32'h7fff_ff00 | 32'($urandom_range(0, 255)));
        3: set_thresholds(1, -32'($urandom_range(0, 32'h0004_0000)), 32'd0);
        4: set_thresholds(1, 32'($urandom), 32'($urandom));
        default: set_thresholds(1, -32'($urandom_range(1, 32'h0100_0000)),
                                32'($urandom_range(1, 32'h0100_0000)));
      endcase
      no_idle = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        // Long receiver hold while input keeps coming: pipeline fills up.
        if (ph == 2 && n == 10) hold_request = 200;
        // Sender pause until every outstanding result has come back.
        if (ph == 4 && n == 50)
          while (sb.pending.size() != 0) @(negedge clk);
        send_word(rand_departure(), rand_stddev());
      end
    end
    no_idle = 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> huber_qc_weight_unit.f
rtl/hqw_pkg.sv
rtl/hqw_if.sv
rtl/hqw_prep.sv
rtl/hqw_cell.sv
rtl/hqw_final.sv
rtl/huber_qc_weight_unit.sv
rtl/hqw_checker.sv
dv/hqw_sb_pkg.sv
dv/huber_qc_weight_unit_tb.sv
